>>> src/sva_pkg.sv
package sva_pkg;

    localparam int VOICE_COUNT = 16;
    localparam int VOICE_BITS  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int STEP_BITS   = 32;
    localparam int OPC_W       = 2;
    localparam int CHAN_W      = 4;
    localparam int KEY_W       = 7;
    localparam int VEL_W       = 7;
    localparam int IDX_W       = 4;
    localparam int BEND_W      = 14;
    localparam int SEL_W       = 6;
    localparam int MULT_W      = 17;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = STEP_BITS + MULT_W;

    typedef enum logic [OPC_W-1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_BEND     = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ON,
        ST_MISS,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    // one voice entry as kept in the table memory
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [CHAN_W-1:0]    chan;
        logic [VEL_W-1:0]     vol;
        logic [STEP_BITS-1:0] base;
        logic [STEP_BITS-1:0] cur;
    } t_voice;

    localparam int VOICE_W = $bits(t_voice);

    typedef struct packed {
        logic [IDX_W-1:0]     idx;
        logic                 hit;
        logic                 active;
        logic [KEY_W-1:0]     key;
        logic [CHAN_W-1:0]    chan;
        logic [VEL_W-1:0]     vol;
        logic [STEP_BITS-1:0] step;
        logic                 restart;
        logic                 last;
    } t_result;

    function automatic t_result miss_result();
        t_result res;
        res      = '0;
        res.last = 1'b1;
        return res;
    endfunction

    // Q1.16 bend multipliers, bend[13:8] selects
    function automatic logic [MULT_W-1:0] bend_mult(input logic [SEL_W-1:0] sel);
        logic [MULT_W-1:0] m;
        case (sel)
            6'd0:  m = 17'd61858;  6'd1:  m = 17'd61970;
            6'd2:  m = 17'd62081;  6'd3:  m = 17'd62194;
            6'd4:  m = 17'd62306;  6'd5:  m = 17'd62419;
            6'd6:  m = 17'd62531;  6'd7:  m = 17'd62644;
            6'd8:  m = 17'd62757;  6'd9:  m = 17'd62871;
            6'd10: m = 17'd62984;  6'd11: m = 17'd63098;
            6'd12: m = 17'd63212;  6'd13: m = 17'd63326;
            6'd14: m = 17'd63441;  6'd15: m = 17'd63556;
            6'd16: m = 17'd63670;  6'd17: m = 17'd63785;
            6'd18: m = 17'd63901;  6'd19: m = 17'd64016;
            6'd20: m = 17'd64132;  6'd21: m = 17'd64248;
            6'd22: m = 17'd64364;  6'd23: m = 17'd64480;
            6'd24: m = 17'd64596;  6'd25: m = 17'd64713;
            6'd26: m = 17'd64830;  6'd27: m = 17'd64947;
            6'd28: m = 17'd65065;  6'd29: m = 17'd65182;
            6'd30: m = 17'd65300;  6'd31: m = 17'd65418;
            6'd32: m = 17'd65536;  6'd33: m = 17'd65654;
            6'd34: m = 17'd65773;  6'd35: m = 17'd65892;
            6'd36: m = 17'd66011;  6'd37: m = 17'd66130;
            6'd38: m = 17'd66250;  6'd39: m = 17'd66369;
            6'd40: m = 17'd66489;  6'd41: m = 17'd66609;
            6'd42: m = 17'd66730;  6'd43: m = 17'd66850;
            6'd44: m = 17'd66971;  6'd45: m = 17'd67092;
            6'd46: m = 17'd67213;  6'd47: m = 17'd67335;
            6'd48: m = 17'd67456;  6'd49: m = 17'd67578;
            6'd50: m = 17'd67700;  6'd51: m = 17'd67823;
            6'd52: m = 17'd67945;  6'd53: m = 17'd68068;
            6'd54: m = 17'd68191;  6'd55: m = 17'd68314;
            6'd56: m = 17'd68438;  6'd57: m = 17'd68561;
            6'd58: m = 17'd68685;  6'd59: m = 17'd68809;
            6'd60: m = 17'd68933;  6'd61: m = 17'd69058;
            6'd62: m = 17'd69183;  6'd63: m = 17'd69308;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

>>> src/sva_ram.sv
module sva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/sva_scale.sv
module sva_scale (
    input  logic                          i_clk,
    input  logic [sva_pkg::STEP_BITS-1:0] i_base,
    input  logic [sva_pkg::MULT_W-1:0]    i_mult,
    output logic [sva_pkg::STEP_BITS-1:0] o_step
);
    import sva_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic              ovf;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_base) * PROD_W'(i_mult);
    end

    // floor(base * mult / 2^16), clamped to the step range
    assign ovf    = |r_prod[PROD_W-1:FRAC_BITS+STEP_BITS];
    assign o_step = ovf ? {STEP_BITS{1'b1}} : r_prod[FRAC_BITS+STEP_BITS-1:FRAC_BITS];

endmodule

>>> src/synth_voice_allocator.sv
// Polyphonic voice allocator.
// Request channel: drive the item fields with start high; the request is
// taken at a clock edge where start is high and busy is low. busy stays
// high until the last result of that request is shown.
// Result channel: each result is on the o_ ports for one cycle with o_valid
// high; o_last marks the final result of a request. The receiver cannot
// stall, so results are never held back.
// Note on with nonzero velocity, and opcode 3: one result, registered after
// the ST_ON or ST_MISS state; busy drops in the same cycle that it shows.
// Note off and pitch bend: the voice table memory is read one voice per
// cycle (one read port, registered read), then a two-stage tail (match
// check and multiply, then write-back). The final result is shown once the
// scan pipeline has drained; bend results for retuned voices come out one
// by one, each held until the next match is found.
// Reset (synchronous, i_rst_n low) marks all voices free and drops busy;
// the table memory itself is not cleared; free voices never match in a scan.
module synth_voice_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sva_pkg::OPC_W-1:0]     i_opcode,
    input  logic [sva_pkg::CHAN_W-1:0]    i_channel,
    input  logic [sva_pkg::KEY_W-1:0]     i_key,
    input  logic [sva_pkg::VEL_W-1:0]     i_velocity,
    input  logic [sva_pkg::STEP_BITS-1:0] i_key_step,
    input  logic [sva_pkg::BEND_W-1:0]    i_bend,
    output logic                          o_valid,
    output logic [sva_pkg::IDX_W-1:0]     o_voice_index,
    output logic                          o_hit,
    output logic                          o_voice_active,
    output logic [sva_pkg::KEY_W-1:0]     o_note_key,
    output logic [sva_pkg::CHAN_W-1:0]    o_voice_channel,
    output logic [sva_pkg::VEL_W-1:0]     o_volume,
    output logic [sva_pkg::STEP_BITS-1:0] o_step_value,
    output logic                          o_restart_phase,
    output logic                          o_last
);
    import sva_pkg::*;

    t_state                r_state, n_state;
    logic [VOICE_COUNT-1:0] r_used, n_used;
    logic [VOICE_BITS-1:0]  r_addr, n_addr;
    logic                  r_found, n_found;
    logic                  r_pend_v, n_pend_v;
    t_result               r_pend, n_pend;
    logic                  r_out_v, n_out_v;
    t_result               r_out, n_out;

    // latched request
    t_op                   r_op;
    logic [CHAN_W-1:0]     r_chan;
    logic [KEY_W-1:0]      r_key;
    logic [VEL_W-1:0]      r_vel;
    logic [STEP_BITS-1:0]  r_kstep;
    logic [MULT_W-1:0]     r_mult;

    // scan pipeline
    logic                  r_s1_v;
    logic [VOICE_BITS-1:0] r_s1_idx;
    logic                  r_s2_v;
    logic                  r_s2_match;
    logic [VOICE_BITS-1:0] r_s2_idx;
    t_voice                r_s2_voice;

    t_op                   eff_op;
    logic                  accept;
    t_voice                ram_q;
    logic                  ram_we;
    logic [VOICE_BITS-1:0] ram_waddr;
    t_voice                ram_wdata;
    logic                  s1_match;
    logic [STEP_BITS-1:0]  scaled;
    logic                  free_found;
    logic [VOICE_BITS-1:0] free_idx;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        eff_op = t_op'(i_opcode);
        if (eff_op == OP_NOTE_ON && i_velocity == '0) begin
            eff_op = OP_NOTE_OFF;
        end
    end

    sva_ram #(
        .WIDTH (VOICE_W),
        .DEPTH (VOICE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    sva_scale u_scale (
        .i_clk  (i_clk),
        .i_base (ram_q.base),
        .i_mult (r_mult),
        .o_step (scaled)
    );

    assign s1_match = r_used[r_s1_idx] &&
                      ((r_op == OP_BEND) ? (ram_q.chan == r_chan) : (ram_q.key == r_key));

    // lowest free voice for note on
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
            if (!r_used[v]) begin
                free_found = 1'b1;
                free_idx   = VOICE_BITS'(v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= eff_op;
            r_chan  <= i_channel;
            r_key   <= i_key;
            r_vel   <= i_velocity;
            r_kstep <= i_key_step;
            r_mult  <= bend_mult(i_bend[BEND_W-1 -: SEL_W]);
        end
        r_s1_idx   <= r_addr;
        r_s2_idx   <= r_s1_idx;
        r_s2_match <= s1_match;
        r_s2_voice <= ram_q;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_addr   <= '0;
            r_found  <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_addr   <= n_addr;
            r_found  <= n_found;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            r_s1_v   <= (r_state == ST_SCAN);
            r_s2_v   <= r_s1_v;
        end
    end

    always_comb begin
        t_result res;
        t_voice  upd;

        n_state   = r_state;
        n_used    = r_used;
        n_addr    = r_addr;
        n_found   = r_found;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_out_v   = 1'b0;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_s2_idx;

        // write-back stage: note off frees, bend retunes
        upd = r_s2_voice;
        res = '0;
        res.idx  = IDX_W'(r_s2_idx);
        res.hit  = 1'b1;
        res.key  = r_s2_voice.key;
        res.vol  = r_s2_voice.vol;
        if (r_op == OP_BEND) begin
            upd.cur     = scaled;
            res.active  = 1'b1;
            res.chan    = r_s2_voice.chan;
            res.step    = scaled;
        end else begin
            upd.chan    = '0;
            upd.base    = r_kstep;
            upd.cur     = r_kstep;
            res.active  = 1'b0;
            res.chan    = '0;
            res.step    = r_kstep;
        end
        ram_wdata = upd;

        if (r_s2_v && r_s2_match && !(r_op == OP_NOTE_OFF && r_found)) begin
            ram_we = 1'b1;
            if (r_op == OP_NOTE_OFF) begin
                n_used[r_s2_idx] = 1'b0;
                n_found          = 1'b1;
            end
            // previous match is now known not to be the last one
            if (r_pend_v) begin
                n_out_v = 1'b1;
                n_out   = r_pend;
            end
            n_pend_v = 1'b1;
            n_pend   = res;
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_addr   = '0;
                    n_found  = 1'b0;
                    n_pend_v = 1'b0;
                    case (eff_op)
                        OP_NOTE_ON:  n_state = ST_ON;
                        OP_NOTE_OFF: n_state = ST_SCAN;
                        OP_BEND:     n_state = ST_SCAN;
                        default:     n_state = ST_MISS;
                    endcase
                end
            end
            ST_ON: begin
                n_out_v = 1'b1;
                n_state = ST_IDLE;
                if (free_found) begin
                    ram_we         = 1'b1;
                    ram_waddr      = free_idx;
                    ram_wdata.key  = r_key;
                    ram_wdata.chan = r_chan;
                    ram_wdata.vol  = r_vel;
                    ram_wdata.base = r_kstep;
                    ram_wdata.cur  = r_kstep;
                    n_used[free_idx] = 1'b1;
                    n_out.idx     = IDX_W'(free_idx);
                    n_out.hit     = 1'b1;
                    n_out.active  = 1'b1;
                    n_out.key     = r_key;
                    n_out.chan    = r_chan;
                    n_out.vol     = r_vel;
                    n_out.step    = r_kstep;
                    n_out.restart = 1'b1;
                    n_out.last    = 1'b1;
                end else begin
                    n_out = miss_result();
                end
            end
            ST_MISS: begin
                n_out_v = 1'b1;
                n_out   = miss_result();
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                n_addr = VOICE_BITS'(r_addr + 1'b1);
                if (r_addr == VOICE_BITS'(VOICE_COUNT - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_v && !r_s2_v) begin
                    n_out_v = 1'b1;
                    if (r_pend_v) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out = miss_result();
                    end
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid         = r_out_v;
    assign o_voice_index   = r_out.idx;
    assign o_hit           = r_out.hit;
    assign o_voice_active  = r_out.active;
    assign o_note_key      = r_out.key;
    assign o_voice_channel = r_out.chan;
    assign o_volume        = r_out.vol;
    assign o_step_value    = r_out.step;
    assign o_restart_phase = r_out.restart;
    assign o_last          = r_out.last;

    // request completion goes with its final result
    a_done_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_valid && o_last))
        else $error("busy dropped without a final result");

    // a non-final result means the request is still in progress
    a_mid_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("intermediate result after request finished");

    a_miss_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_last && o_step_value == '0 && !o_voice_active))
        else $error("miss result malformed");

    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_state == ST_SCAN || r_state == ST_DRAIN))
        else $error("scan pipeline active outside a scan");

endmodule

>>> bench/synth_voice_allocator_tb.sv
`timescale 1ns / 100ps

module synth_voice_allocator_tb;
    import sva_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int RANDOM_EVENTS = 385;

    typedef struct {
        t_op                  op;
        logic [CHAN_W-1:0]    chan;
        logic [KEY_W-1:0]     key;
        logic [VEL_W-1:0]     vel;
        logic [STEP_BITS-1:0] kstep;
        logic [BEND_W-1:0]    bend;
    } t_midi_event;

    typedef struct {
        t_midi_event ev;
        bit          typed;
        t_result     want;
    } t_script_row;

    // Q1.16 pitch wheel multipliers, indexed by bend[13:8]
    int unsigned q16_mult [64] = '{
        61858, 61970, 62081, 62194, 62306, 62419, 62531, 62644,
        62757, 62871, 62984, 63098, 63212, 63326, 63441, 63556,
        63670, 63785, 63901, 64016, 64132, 64248, 64364, 64480,
        64596, 64713, 64830, 64947, 65065, 65182, 65300, 65418,
        65536, 65654, 65773, 65892, 66011, 66130, 66250, 66369,
        66489, 66609, 66730, 66850, 66971, 67092, 67213, 67335,
        67456, 67578, 67700, 67823, 67945, 68068, 68191, 68314,
        68438, 68561, 68685, 68809, 68933, 69058, 69183, 69308
    };

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic [OPC_W-1:0]     i_opcode   = '0;
    logic [CHAN_W-1:0]    i_channel  = '0;
    logic [KEY_W-1:0]     i_key      = '0;
    logic [VEL_W-1:0]     i_velocity = '0;
    logic [STEP_BITS-1:0] i_key_step = '0;
    logic [BEND_W-1:0]    i_bend     = '0;
    logic                 busy;
    logic                 o_valid;
    logic [IDX_W-1:0]     o_voice_index;
    logic                 o_hit;
    logic                 o_voice_active;
    logic [KEY_W-1:0]     o_note_key;
    logic [CHAN_W-1:0]    o_voice_channel;
    logic [VEL_W-1:0]     o_volume;
    logic [STEP_BITS-1:0] o_step_value;
    logic                 o_restart_phase;
    logic                 o_last;

    synth_voice_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_channel       (i_channel),
        .i_key           (i_key),
        .i_velocity      (i_velocity),
        .i_key_step      (i_key_step),
        .i_bend          (i_bend),
        .o_valid         (o_valid),
        .o_voice_index   (o_voice_index),
        .o_hit           (o_hit),
        .o_voice_active  (o_voice_active),
        .o_note_key      (o_note_key),
        .o_voice_channel (o_voice_channel),
        .o_volume        (o_volume),
        .o_step_value    (o_step_value),
        .o_restart_phase (o_restart_phase),
        .o_last          (o_last)
    );

    // shadow voice table
    bit                   v_used [VOICE_COUNT];
    logic [KEY_W-1:0]     v_key  [VOICE_COUNT];
    logic [CHAN_W-1:0]    v_chan [VOICE_COUNT];
    logic [VEL_W-1:0]     v_vol  [VOICE_COUNT];
    logic [STEP_BITS-1:0] v_base [VOICE_COUNT];
    logic [STEP_BITS-1:0] v_cur  [VOICE_COUNT];

    t_result     voice_reports [VOICE_COUNT];
    t_result     due_reports [$];
    t_script_row midi_script [$];
    int          fail_count = 0;
    int unsigned cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("synth_voice_allocator test failed");
            $finish;
        end
    end

    function automatic t_result no_voice();
        t_result r;
        r      = '0;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_result voice_res(int idx, bit act, int key, int ch, int vol,
                                          logic [STEP_BITS-1:0] st, bit rs);
        t_result r;
        r         = '0;
        r.idx     = IDX_W'(idx);
        r.hit     = 1'b1;
        r.active  = act;
        r.key     = KEY_W'(key);
        r.chan    = CHAN_W'(ch);
        r.vol     = VEL_W'(vol);
        r.step    = st;
        r.restart = rs;
        r.last    = 1'b1;
        return r;
    endfunction

    function automatic t_script_row row_of(t_op op, int ch, int key, int vel,
                                           logic [STEP_BITS-1:0] ks, int bend);
        t_script_row r;
        r.ev.op    = op;
        r.ev.chan  = CHAN_W'(ch);
        r.ev.key   = KEY_W'(key);
        r.ev.vel   = VEL_W'(vel);
        r.ev.kstep = ks;
        r.ev.bend  = BEND_W'(bend);
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic t_script_row typed_row(t_script_row r, t_result w);
        r.typed = 1'b1;
        r.want  = w;
        return r;
    endfunction

    // floor(base * mult / 2^16), saturated to the step width
    function automatic logic [STEP_BITS-1:0] bent_step(logic [STEP_BITS-1:0] base,
                                                       int unsigned mult);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] p;
        hi = 64'(base >> 16);
        lo = 64'(base[15:0]);
        p  = hi * 64'(mult) + ((lo * 64'(mult)) >> 16);
        return (p > 64'({STEP_BITS{1'b1}})) ? {STEP_BITS{1'b1}} : p[STEP_BITS-1:0];
    endfunction

    function automatic void report_voice(int slot, int v, bit rs);
        voice_reports[slot] = voice_res(v, v_used[v], int'(v_key[v]), int'(v_chan[v]),
                                        int'(v_vol[v]), v_cur[v], rs);
        voice_reports[slot].last = 1'b0;
    endfunction

    // updates the shadow table, returns how many voice reports the event gives
    function automatic int apply_midi_event(t_midi_event ev);
        t_op         op;
        int          n;
        int unsigned mult;
        n    = 0;
        op   = ev.op;
        mult = q16_mult[ev.bend[13:8]];
        if (op == OP_NOTE_ON && ev.vel == 0)
            op = OP_NOTE_OFF;
        case (op)
            OP_NOTE_ON: begin
                for (int v = 0; v < VOICE_COUNT; v++) begin
                    if (!v_used[v]) begin
                        v_used[v] = 1'b1;
                        v_key[v]  = ev.key;
                        v_chan[v] = ev.chan;
                        v_vol[v]  = ev.vel;
                        v_base[v] = ev.kstep;
                        v_cur[v]  = ev.kstep;
                        report_voice(0, v, 1'b1);
                        n = 1;
                        break;
                    end
                end
            end
            OP_NOTE_OFF: begin
                for (int v = 0; v < VOICE_COUNT; v++) begin
                    if (v_used[v] && v_key[v] == ev.key) begin
                        v_used[v] = 1'b0;
                        v_chan[v] = '0;
                        v_base[v] = ev.kstep;
                        v_cur[v]  = ev.kstep;
                        report_voice(0, v, 1'b0);
                        n = 1;
                        break;
                    end
                end
            end
            OP_BEND: begin
                for (int v = 0; v < VOICE_COUNT; v++) begin
                    if (v_used[v] && v_chan[v] == ev.chan) begin
                        v_cur[v] = bent_step(v_base[v], mult);
                        report_voice(n, v, 1'b0);
                        n++;
                    end
                end
            end
            default: ;
        endcase
        if (n == 0) begin
            voice_reports[0] = no_voice();
            n = 1;
        end else begin
            voice_reports[n-1].last = 1'b1;
        end
        return n;
    endfunction

    function automatic t_midi_event draw_event(int n);
        t_midi_event ev;
        int          r;
        int          on_pct;
        int          off_pct;
        int          live [$];
        for (int v = 0; v < VOICE_COUNT; v++)
            if (v_used[v]) live.push_back(v);
        // alternate filling and draining phases so the table runs full and empty
        on_pct  = ((n / 64) % 2 == 0) ? 55 : 28;
        off_pct = ((n / 64) % 2 == 0) ? 18 : 45;
        ev.chan = ($urandom_range(99) < 70) ? CHAN_W'($urandom_range(3))
                                            : CHAN_W'($urandom_range(15));
        ev.key  = ($urandom_range(1) == 1) ? KEY_W'($urandom_range(67, 60))
                                           : KEY_W'($urandom_range(127));
        ev.vel  = ($urandom_range(99) < 8) ? '0 : VEL_W'($urandom_range(127, 1));
        r = $urandom_range(99);
        ev.kstep = (r < 10) ? '1 : (r < 15) ? '0 : STEP_BITS'($urandom);
        r = $urandom_range(99);
        ev.bend = (r < 8) ? '1 : (r < 16) ? '0 : BEND_W'($urandom);
        r = $urandom_range(99);
        if (r < on_pct) begin
            ev.op = OP_NOTE_ON;
        end else if (r < on_pct + off_pct) begin
            ev.op = OP_NOTE_OFF;
            if (live.size() > 0 && $urandom_range(99) < 80)
                ev.key = v_key[live[$urandom_range(live.size() - 1)]];
        end else if (r < 96) begin
            ev.op = OP_BEND;
            if (live.size() > 0 && $urandom_range(99) < 75)
                ev.chan = v_chan[live[$urandom_range(live.size() - 1)]];
        end else begin
            ev.op = OP_NONE;
        end
        return ev;
    endfunction

    // start stays high after acceptance; the next call lowers it only for a gap
    task automatic issue(t_midi_event ev, int gap, bit typed, t_result want);
        int n;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_opcode   <= ev.op;
        i_channel  <= ev.chan;
        i_key      <= ev.key;
        i_velocity <= ev.vel;
        i_key_step <= ev.kstep;
        i_bend     <= ev.bend;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n = apply_midi_event(ev);
        if (typed) begin
            due_reports.push_back(want);
        end else begin
            for (int k = 0; k < n; k++)
                due_reports.push_back(voice_reports[k]);
        end
    endtask

    function automatic int draw_gap(int n);
        return ((n / 40) % 3 == 2) ? 0 : $urandom_range(14);
    endfunction

    task automatic check_field(string name, logic [STEP_BITS-1:0] exp_v,
                               logic [STEP_BITS-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (o_valid) begin
            if (due_reports.size() == 0) begin
                $error("voice report with no request pending");
                fail_count++;
            end else begin
                want = due_reports.pop_front();
                check_field("voice_index",   STEP_BITS'(want.idx),
                            STEP_BITS'(o_voice_index));
                check_field("hit",           STEP_BITS'(want.hit), STEP_BITS'(o_hit));
                check_field("voice_active",  STEP_BITS'(want.active),
                            STEP_BITS'(o_voice_active));
                check_field("note_key",      STEP_BITS'(want.key), STEP_BITS'(o_note_key));
                check_field("voice_channel", STEP_BITS'(want.chan),
                            STEP_BITS'(o_voice_channel));
                check_field("volume",        STEP_BITS'(want.vol), STEP_BITS'(o_volume));
                check_field("step_value",    want.step,    o_step_value);
                check_field("restart_phase", STEP_BITS'(want.restart),
                            STEP_BITS'(o_restart_phase));
                check_field("last",          STEP_BITS'(want.last), STEP_BITS'(o_last));
            end
        end
    end

    initial begin
        t_script_row row;
        t_result     unused;
        unused = '0;

        // empty table: misses on note off, bend and opcode 3, then two note ons hit
        midi_script.push_back(typed_row(row_of(OP_NOTE_OFF, 0, 0, 0, '0, 0), no_voice()));
        midi_script.push_back(typed_row(row_of(OP_BEND, 7, 0, 0, '0, 'h1234), no_voice()));
        midi_script.push_back(typed_row(row_of(OP_NONE, 15, 127, 127, '1, 'h3FFF),
                                        no_voice()));
        midi_script.push_back(typed_row(row_of(OP_NOTE_ON, 15, 127, 127, '1, 0),
                                        voice_res(0, 1'b1, 127, 15, 127, '1, 1'b1)));
        midi_script.push_back(typed_row(row_of(OP_NOTE_ON, 0, 0, 1, '0, 'h3FFF),
                                        voice_res(1, 1'b1, 0, 0, 1, '0, 1'b1)));
        // largest step at the top multiplier saturates
        midi_script.push_back(typed_row(row_of(OP_BEND, 15, 5, 9, '0, 'h3FFF),
                                        voice_res(0, 1'b1, 127, 15, 127, '1, 1'b0)));
        midi_script.push_back(row_of(OP_BEND, 15, 0, 0, '1, 0));
        // zero velocity note on releases the voice
        midi_script.push_back(typed_row(row_of(OP_NOTE_ON, 3, 127, 0, 32'h12345678, 0),
                                        voice_res(0, 1'b0, 127, 0, 127, 32'h12345678,
                                                  1'b0)));
        for (int k = 0; k < VOICE_COUNT - 1; k++)
            midi_script.push_back(row_of(OP_NOTE_ON, 9, 10 + k, 20 + 7 * k,
                                         STEP_BITS'($urandom), $urandom_range(16383)));
        midi_script.push_back(typed_row(row_of(OP_NOTE_ON, 9, 50, 64, 32'h0BAD_F00D, 0),
                                        no_voice()));
        midi_script.push_back(row_of(OP_BEND, 9, 0, 0, '0, 'h2000));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (midi_script[i]) begin
            row = midi_script[i];
            issue(row.ev, draw_gap(i), row.typed, row.want);
        end

        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (n == RANDOM_EVENTS / 2) begin
                // hold off until the table has reported everything
                start <= 1'b0;
                @(posedge i_clk);
                while (due_reports.size() != 0) @(posedge i_clk);
            end
            issue(draw_event(n), draw_gap(n), 1'b0, unused);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("synth_voice_allocator test passed");
        end else begin
            $display("synth_voice_allocator test failed");
        end
        $finish;
    end

endmodule
